// ===== src/assert_macros.svh =====
// Concurrent assertion helpers. Building with NO_ASSERTIONS defined leaves them empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising edge while out of reset.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression must never be true while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	`ASSERT_CLKD(lbl, clk, rstn, !(expr), msg)

`else

`define ASSERT_CLKD(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ===== src/sdicrc_pkg.sv =====
`default_nettype none

package sdicrc_pkg;

	localparam int unsigned CrcCharCount = 3;
	localparam logic [15:0] CrcPoly      = 16'hA001;
	localparam logic [7:0]  EncMark      = 8'h40;
	localparam logic [7:0]  ChrCr        = 8'h0D;
	localparam logic [7:0]  ChrLf        = 8'h0A;
	localparam logic [1:0]  FillFull     = 2'(CrcCharCount);

	typedef logic [7:0]  octet_t;
	typedef logic [15:0] crc_t;
	typedef logic [1:0]  fill_t;
	typedef octet_t [CrcCharCount-1:0] window_t;

	// CRC accumulator together with the hold-back window; index 0 is the oldest octet.
	typedef struct packed {
		crc_t    crc;
		window_t window;
		fill_t   fill;
		logic    seen;
	} kept_state_t;

	// Packed so that crc_ok lands in the lowest bit of the result beat.
	typedef struct packed {
		logic frame_error;
		crc_t computed_crc;
		logic crc_ok;
	} result_t;

	localparam kept_state_t KeptReset = '0;

	function automatic logic is_newline(input octet_t b);
		return (b == ChrCr) || (b == ChrLf);
	endfunction

	// Reflected CRC-16 update by one octet, one bit per step.
	function automatic crc_t crc_byte(input crc_t c, input octet_t b);
		crc_t r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CrcPoly;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// Push one octet into the window; the octet that falls out goes into the CRC.
	function automatic kept_state_t keep_octet(input kept_state_t s, input octet_t b);
		kept_state_t r;
		r = s;
		if (s.fill < FillFull) begin
			r.window[s.fill] = b;
			r.fill = s.fill + 2'd1;
		end else begin
			r.crc  = crc_byte(s.crc, s.window[0]);
			r.seen = 1'b1;
			for (int k = 0; k < CrcCharCount - 1; k++) begin
				r.window[k] = s.window[k+1];
			end
			r.window[CrcCharCount-1] = b;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/sdicrc_frame_step.sv =====
`default_nettype none

module sdicrc_frame_step #(
	parameter int unsigned MaxPending = 2,
	localparam int unsigned CntW      = $clog2(MaxPending + 2)
) (
	input  wire  sdicrc_pkg::octet_t      resp_byte,
	input  wire                           last_byte,
	input  wire  sdicrc_pkg::kept_state_t cur,
	input  wire                           overflow_cur,
	input  wire  logic [CntW-1:0]         pend_cnt_cur,
	input  wire  sdicrc_pkg::octet_t      pend_codes_cur [MaxPending],
	output sdicrc_pkg::kept_state_t       nxt,
	output logic                          overflow_nxt,
	output logic [CntW-1:0]               pend_cnt_nxt,
	output sdicrc_pkg::octet_t            pend_codes_nxt [MaxPending],
	output sdicrc_pkg::result_t           result
);

	logic                    nl;
	logic                    ovf_after;
	sdicrc_pkg::kept_state_t flushed;
	sdicrc_pkg::kept_state_t kept;
	sdicrc_pkg::kept_state_t fin;
	sdicrc_pkg::window_t     enc;
	logic                    err;

	assign nl = sdicrc_pkg::is_newline(resp_byte);

	// Held-back CR/LF codes turn out to be inside the frame: keep them ahead of this octet.
	always_comb begin
		flushed = cur;
		for (int k = 0; k < MaxPending; k++) begin
			if (CntW'(k) < pend_cnt_cur) begin
				flushed = sdicrc_pkg::keep_octet(flushed, pend_codes_cur[k]);
			end
		end
		kept = sdicrc_pkg::keep_octet(flushed, resp_byte);
	end

	assign ovf_after = overflow_cur | (!nl && (pend_cnt_cur > CntW'(MaxPending)));
	assign fin       = nl ? cur : kept;

	assign enc[0] = sdicrc_pkg::EncMark | {4'h0, fin.crc[15:12]};
	assign enc[1] = sdicrc_pkg::EncMark | {2'b00, fin.crc[11:6]};
	assign enc[2] = sdicrc_pkg::EncMark | {2'b00, fin.crc[5:0]};

	assign err                 = !fin.seen || (fin.fill < sdicrc_pkg::FillFull) || ovf_after;
	assign result.frame_error  = err;
	assign result.computed_crc = fin.crc;
	assign result.crc_ok       = !err && (enc == fin.window);

	always_comb begin
		pend_codes_nxt = pend_codes_cur;
		if (last_byte) begin
			nxt          = sdicrc_pkg::KeptReset;
			overflow_nxt = 1'b0;
			pend_cnt_nxt = '0;
		end else if (nl) begin
			nxt          = cur;
			overflow_nxt = overflow_cur;
			pend_cnt_nxt = pend_cnt_cur;
			for (int k = 0; k < MaxPending; k++) begin
				if (pend_cnt_cur == CntW'(k)) begin
					pend_codes_nxt[k] = resp_byte;
				end
			end
			// The count saturates one above the limit, which marks an overlong run.
			if (pend_cnt_cur <= CntW'(MaxPending)) begin
				pend_cnt_nxt = pend_cnt_cur + CntW'(1);
			end
		end else begin
			nxt          = kept;
			overflow_nxt = ovf_after;
			pend_cnt_nxt = '0;
		end
	end

endmodule

`default_nettype wire

// ===== src/sdi12_response_crc_check_unit.sv =====
// Channel  Dir  tdata                                   tlast
// s_       in   [7:0] resp_byte                         last_byte
// m_       out  [0] crc_ok, [16:1] computed_crc,        -
//               [17] frame_error, [23:18] zero
//
// One beat is accepted per cycle while no final beat waits on the output register. A frame's
// result is registered from the input register once the output register is free or being emptied.
// The frame state update (up to MAX_PENDING_NEWLINES + 1 chained CRC octet updates) sits
// between the input register and the state and result registers.
// Only a final beat waits on a result still held in the output register; other beats pass.
// arst_n clears the frame state except the held-back codes; each frame's state is cleared again after its final beat.
`default_nettype none
`include "assert_macros.svh"

module sdi12_response_crc_check_unit #(
	parameter int unsigned MAX_PENDING_NEWLINES = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] resp_byte
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata    // [0] crc_ok, [16:1] computed_crc, [17] frame_error
);

	localparam int unsigned CntW = $clog2(MAX_PENDING_NEWLINES + 2);

	logic                    valid_s1;
	sdicrc_pkg::octet_t      byte_s1;
	logic                    last_s1;
	logic                    go_s1;

	sdicrc_pkg::kept_state_t kept_q;
	logic                    overflow_q;
	logic [CntW-1:0]         pend_cnt_q;
	sdicrc_pkg::octet_t      pend_codes_q [MAX_PENDING_NEWLINES];

	sdicrc_pkg::kept_state_t kept_nxt;
	logic                    overflow_nxt;
	logic [CntW-1:0]         pend_cnt_nxt;
	sdicrc_pkg::octet_t      pend_codes_nxt [MAX_PENDING_NEWLINES];
	sdicrc_pkg::result_t     result;

	logic                    valid_s2;
	sdicrc_pkg::result_t     result_s2;

	// A final beat may only advance once the output register is free or being emptied.
	assign go_s1    = valid_s1 && (!last_s1 || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	sdicrc_frame_step #(
		.MaxPending(MAX_PENDING_NEWLINES)
	) u_step (
		.resp_byte     (byte_s1),
		.last_byte     (last_s1),
		.cur           (kept_q),
		.overflow_cur  (overflow_q),
		.pend_cnt_cur  (pend_cnt_q),
		.pend_codes_cur(pend_codes_q),
		.nxt           (kept_nxt),
		.overflow_nxt  (overflow_nxt),
		.pend_cnt_nxt  (pend_cnt_nxt),
		.pend_codes_nxt(pend_codes_nxt),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q     <= sdicrc_pkg::KeptReset;
			overflow_q <= 1'b0;
			pend_cnt_q <= '0;
		end else if (go_s1) begin
			kept_q     <= kept_nxt;
			overflow_q <= overflow_nxt;
			pend_cnt_q <= pend_cnt_nxt;
		end
	end

	// Codes are only read below the pending count, so they need no reset.
	always_ff @(posedge clk) begin
		if (go_s1) begin
			pend_codes_q <= pend_codes_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b000000, result_s2};

	`ASSERT_CLKD(a_last_gives_result, clk, arst_n, (go_s1 && last_s1) |=> valid_s2, "final beat produced no result")
	`ASSERT_CLKD(a_frame_cleared, clk, arst_n, (go_s1 && last_s1) |=> (kept_q.fill == 2'd0 && pend_cnt_q == '0 && !overflow_q), "state not cleared after frame")
	`ASSERT_NEVER(a_ok_without_error, clk, arst_n, valid_s2 && result_s2.crc_ok && result_s2.frame_error, "crc_ok set on a frame error")
	`ASSERT_NEVER(a_seen_needs_full, clk, arst_n, kept_q.seen && (kept_q.fill != sdicrc_pkg::FillFull), "octet left a window that was not full")
	`ASSERT_NEVER(a_pend_saturates, clk, arst_n, pend_cnt_q > CntW'(MAX_PENDING_NEWLINES + 1), "pending count beyond saturation")

endmodule

`default_nettype wire

// ===== tb/sv/crc_verdict_checker.sv =====
`timescale 1ns / 1ps

package sdicrc_arc_pkg;

	// Index 0 is the first of the three characters on the wire.
	typedef sdicrc_pkg::octet_t [sdicrc_pkg::CrcCharCount-1:0] crc_text_t;

	function automatic sdicrc_pkg::crc_t arc16_fold(input sdicrc_pkg::crc_t c,
		input sdicrc_pkg::octet_t b);
		sdicrc_pkg::crc_t r;
		r = c ^ {8'h00, b};
		repeat (8) begin
			r = r[0] ? ((r >> 1) ^ sdicrc_pkg::CrcPoly) : (r >> 1);
		end
		return r;
	endfunction

	function automatic crc_text_t ascii_crc(input sdicrc_pkg::crc_t c);
		crc_text_t t;
		t[0] = sdicrc_pkg::EncMark | {4'h0, c[15:12]};
		t[1] = sdicrc_pkg::EncMark | {2'b00, c[11:6]};
		t[2] = sdicrc_pkg::EncMark | {2'b00, c[5:0]};
		return t;
	endfunction

endpackage

module crc_verdict_checker #(
	parameter int MaxPending = 2
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	input  wire        s_tready,
	input  wire [7:0]  s_tdata,
	input  wire        s_tlast,
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire [23:0] m_tdata,
	output int         fail_count,
	output int         results_due
);

	sdicrc_pkg::crc_t    crc_run;
	sdicrc_pkg::octet_t  win [sdicrc_pkg::CrcCharCount];
	int unsigned         win_fill;
	int unsigned         nl_run;
	sdicrc_pkg::octet_t  nl_codes [4];
	logic                crc_fed;
	logic                nl_overflow;
	sdicrc_pkg::result_t awaited_verdicts [$];

	task clear_frame();
		crc_run     = '0;
		win_fill    = 0;
		nl_run      = 0;
		crc_fed     = 1'b0;
		nl_overflow = 1'b0;
		foreach (win[k]) win[k] = '0;
		foreach (nl_codes[k]) nl_codes[k] = '0;
	endtask

	task report_mismatch(input string field, input logic [23:0] got, input logic [23:0] want);
		if (fail_count < 40) begin
			$display("checker: %0t %s mismatch, got %0h want %0h", $time, field, got, want);
		end
		fail_count++;
	endtask

	// The oldest octet in the window falls out into the CRC once the window is full.
	task push_kept(input sdicrc_pkg::octet_t b);
		if (win_fill < sdicrc_pkg::CrcCharCount) begin
			win[win_fill] = b;
			win_fill++;
		end else begin
			crc_run = sdicrc_arc_pkg::arc16_fold(crc_run, win[0]);
			crc_fed = 1'b1;
			for (int k = 0; k < sdicrc_pkg::CrcCharCount - 1; k++) win[k] = win[k+1];
			win[sdicrc_pkg::CrcCharCount-1] = b;
		end
	endtask

	task take_octet(input sdicrc_pkg::octet_t b, input logic last);
		sdicrc_pkg::result_t       v;
		sdicrc_arc_pkg::crc_text_t t;
		logic                      err;
		logic                      same;
		if (b == sdicrc_pkg::ChrCr || b == sdicrc_pkg::ChrLf) begin
			if (!last) begin
				if (nl_run < MaxPending) nl_codes[nl_run] = b;
				if (nl_run <= MaxPending) nl_run++;
				return;
			end
			// A final CR or LF drops the whole pending run as trailing.
			nl_run = 0;
		end else begin
			// An ordinary octet proves the pending run was inside the frame.
			if (nl_run > MaxPending) nl_overflow = 1'b1;
			for (int k = 0; k < nl_run && k < MaxPending; k++) push_kept(nl_codes[k]);
			nl_run = 0;
			push_kept(b);
			if (!last) return;
		end
		err  = !crc_fed || win_fill < sdicrc_pkg::CrcCharCount || nl_overflow;
		t    = sdicrc_arc_pkg::ascii_crc(crc_run);
		same = 1'b1;
		for (int k = 0; k < sdicrc_pkg::CrcCharCount; k++) begin
			if (win[k] != t[k]) same = 1'b0;
		end
		v.crc_ok       = !err && same;
		v.computed_crc = crc_run;
		v.frame_error  = err;
		awaited_verdicts.push_back(v);
		clear_frame();
	endtask

	task check_result(input logic [23:0] beat);
		sdicrc_pkg::result_t got;
		sdicrc_pkg::result_t want;
		got = beat[17:0];
		if (awaited_verdicts.size() == 0) begin
			report_mismatch("result with none due", beat, '0);
			return;
		end
		want = awaited_verdicts.pop_front();
		if (got.crc_ok !== want.crc_ok) report_mismatch("crc_ok", got.crc_ok, want.crc_ok);
		if (got.computed_crc !== want.computed_crc) begin
			report_mismatch("computed_crc", got.computed_crc, want.computed_crc);
		end
		if (got.frame_error !== want.frame_error) begin
			report_mismatch("frame_error", got.frame_error, want.frame_error);
		end
		if (beat[23:18] !== 6'h00) report_mismatch("padding", beat[23:18], '0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			awaited_verdicts.delete();
			fail_count  = 0;
			results_due = 0;
		end else begin
			if (s_tvalid && s_tready) take_octet(s_tdata, s_tlast);
			if (m_tvalid && m_tready) check_result(m_tdata);
			results_due = awaited_verdicts.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int MaxPending  = 2;
	localparam int BeatTarget  = 1150;
	localparam int HoldCycles  = 400;
	localparam int CycleLimit  = 200000;
	localparam int SettleTicks = 8;

	typedef enum int {RxOpen, RxCoin, RxEveryFourth, RxMostly} rx_mode_t;
	typedef enum int {FrSound, FrCorrupt, FrOverflow, FrNoise, FrShort} frame_kind_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [23:0] m_tdata;

	int                 fail_count;
	int                 results_due;
	int                 beats_sent  = 0;
	int                 burst_left  = 0;
	int                 cycle_count = 0;
	bit                 hold_go     = 1'b0;
	sdicrc_pkg::octet_t frame_q [$];

	sdi12_response_crc_check_unit #(
		.MAX_PENDING_NEWLINES(MaxPending)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	crc_verdict_checker #(
		.MaxPending(MaxPending)
	) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: done, errors");
		$finish;
	end

	// Receiver: stall patterns picked at random phase by phase, plus one long hold-off.
	initial begin
		int       phase;
		rx_mode_t mode;
		phase = 0;
		mode  = RxOpen;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_go) begin
				m_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_go = 1'b0;
			end else begin
				if (phase == 0) begin
					mode  = rx_mode_t'($urandom_range(0, 3));
					phase = $urandom_range(16, 96);
				end
				phase--;
				case (mode)
					RxOpen:        m_tready <= 1'b1;
					RxCoin:        m_tready <= ($urandom_range(0, 1) == 1);
					RxEveryFourth: m_tready <= (phase % 4 == 0);
					default:       m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_beat(input sdicrc_pkg::octet_t b, input logic last);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		beats_sent++;
		burst_left--;
		if (burst_left == 0) s_tvalid <= 1'b0;
	endtask

	task automatic send_frame();
		foreach (frame_q[k]) send_beat(frame_q[k], k == frame_q.size() - 1);
	endtask

	task automatic drain();
		if (burst_left != 0) begin
			burst_left = 0;
			s_tvalid <= 1'b0;
		end
		while (results_due != 0) @(negedge clk);
		repeat (SettleTicks) @(negedge clk);
	endtask

	function automatic sdicrc_pkg::octet_t plain_octet();
		sdicrc_pkg::octet_t b;
		do b = sdicrc_pkg::octet_t'($urandom_range(0, 255)); while (sdicrc_pkg::is_newline(b));
		return b;
	endfunction

	function automatic sdicrc_pkg::octet_t nl_octet();
		return ($urandom_range(0, 1) == 1) ? sdicrc_pkg::ChrCr : sdicrc_pkg::ChrLf;
	endfunction

	// Appends the CRC characters over everything queued so far, then a trailing run.
	task automatic seal_frame(input int trail);
		sdicrc_pkg::crc_t          c;
		sdicrc_arc_pkg::crc_text_t t;
		c = '0;
		foreach (frame_q[k]) c = sdicrc_arc_pkg::arc16_fold(c, frame_q[k]);
		t = sdicrc_arc_pkg::ascii_crc(c);
		for (int k = 0; k < sdicrc_pkg::CrcCharCount; k++) frame_q.push_back(t[k]);
		repeat (trail) frame_q.push_back(nl_octet());
	endtask

	task automatic build_sound_frame(input int body_len, input int trail);
		frame_q.delete();
		for (int k = 0; k < body_len; k++) begin
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, MaxPending)) frame_q.push_back(nl_octet());
			end
			frame_q.push_back(plain_octet());
		end
		seal_frame(trail);
	endtask

	task automatic build_random_frame();
		int          pick;
		int          body_len;
		frame_kind_t kind;
		pick = $urandom_range(0, 10);
		kind = (pick < 6) ? FrSound : (pick < 8) ? FrCorrupt : (pick == 8) ? FrOverflow
			: (pick == 9) ? FrNoise : FrShort;
		body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
		case (kind)
			FrSound: build_sound_frame(body_len, $urandom_range(0, 3));
			FrCorrupt: begin
				build_sound_frame(body_len, $urandom_range(0, 1));
				pick = $urandom_range(0, frame_q.size() - 1);
				frame_q[pick] ^= sdicrc_pkg::octet_t'(1 << $urandom_range(0, 7));
			end
			FrOverflow: begin
				build_sound_frame(body_len, $urandom_range(0, 2));
				repeat ($urandom_range(MaxPending + 1, MaxPending + 4)) begin
					frame_q.insert(1, nl_octet());
				end
			end
			FrNoise: begin
				frame_q.delete();
				repeat ($urandom_range(1, 12)) begin
					frame_q.push_back(($urandom_range(0, 2) == 0) ? nl_octet()
						: sdicrc_pkg::octet_t'($urandom_range(0, 255)));
				end
			end
			default: begin
				frame_q.delete();
				repeat ($urandom_range(1, 3)) frame_q.push_back(plain_octet());
				if ($urandom_range(0, 1) == 1) frame_q.push_back(nl_octet());
			end
		endcase
	endtask

	initial begin
		int  next_pause;
		bit  held;
		next_pause = 300;
		held       = 1'b0;
		@(posedge arst_n);
		@(negedge clk);

		// Single-octet frames at both extremes, and a frame that is only a final LF.
		frame_q = '{8'h00};
		send_frame();
		frame_q = '{8'hFF};
		send_frame();
		frame_q = '{sdicrc_pkg::ChrLf};
		send_frame();
		// Shortest frame that can pass.
		frame_q = '{8'hFF};
		seal_frame(0);
		send_frame();
		// Leading CR/LF kept as inner data, trailing CR/LF dropped.
		frame_q = '{sdicrc_pkg::ChrCr, sdicrc_pkg::ChrLf, 8'h00};
		seal_frame(2);
		send_frame();
		// An inner run one longer than the pending limit.
		frame_q = '{8'h41, sdicrc_pkg::ChrCr, sdicrc_pkg::ChrLf, sdicrc_pkg::ChrCr, 8'h42};
		send_frame();
		// Last CRC character wrong.
		frame_q = '{8'h80};
		seal_frame(0);
		frame_q[frame_q.size() - 1] ^= 8'h01;
		send_frame();
		drain();

		while (beats_sent < BeatTarget) begin
			if (beats_sent >= next_pause) begin
				drain();
				next_pause += 300;
			end
			if (!held && beats_sent >= 450) begin
				// Short frames against a blocked result side, so final beats back up.
				held = 1'b1;
				drain();
				hold_go = 1'b1;
				repeat (30) begin
					frame_q = '{plain_octet(), plain_octet()};
					send_frame();
				end
			end
			build_random_frame();
			send_frame();
		end
		drain();

		if (fail_count == 0 && results_due == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/sdicrc_pkg.sv
src/sdicrc_frame_step.sv
src/sdi12_response_crc_check_unit.sv
tb/sv/crc_verdict_checker.sv
tb/sv/tb.sv
